>>> design/ibs_pkg.sv
`timescale 1ns / 1ps

package ibs_pkg;

   localparam int DATA_W            = 32;
   localparam int MAX_ITEMS_DEFAULT = 64;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PASS_CHECK,
      S_RUN_CHECK,
      S_READ,
      S_MERGE,
      S_OUT_READ,
      S_OUT_SHOW
   } state_type;

   typedef struct packed {
      logic store;
      logic pass_init;
      logic pass_next;
      logic run_init;
      logic rd_merge;
      logic merge_step;
      logic run_next;
      logic out_init;
      logic out_read;
      logic out_next;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic need_pass;
      logic run_avail;
      logic run_end;
      logic out_last;
   } status_type;

endpackage

>>> design/ibs_if.sv
`timescale 1ns / 1ps

interface ibs_req_if import ibs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] value;
   logic              last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface ibs_rsp_if import ibs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sorted_value;
   logic              final_res;
   logic              overflow;

   modport source (output valid, output sorted_value, output final_res, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input final_res, input overflow,
                   output ready);
endinterface

>>> design/ibs_ctrl.sv
`timescale 1ns / 1ps

module ibs_ctrl import ibs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_last) state_in = S_PASS_CHECK;
         end
         S_PASS_CHECK: begin
            state_in = status.need_pass ? S_RUN_CHECK : S_OUT_READ;
         end
         S_RUN_CHECK: begin
            state_in = status.run_avail ? S_READ : S_PASS_CHECK;
         end
         S_READ: begin
            state_in = S_MERGE;
         end
         S_MERGE: begin
            state_in = status.run_end ? S_RUN_CHECK : S_READ;
         end
         S_OUT_READ: begin
            state_in = S_OUT_SHOW;
         end
         S_OUT_SHOW: begin
            if (rsp_ready) state_in = status.out_last ? S_IDLE : S_OUT_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.store     = req_valid;
            cmd.pass_init = req_valid && req_last;
         end
         S_PASS_CHECK: begin
            cmd.out_init = !status.need_pass;
         end
         S_RUN_CHECK: begin
            cmd.run_init  = status.run_avail;
            cmd.pass_next = !status.run_avail;
         end
         S_READ: begin
            cmd.rd_merge = 1'b1;
         end
         S_MERGE: begin
            cmd.merge_step = 1'b1;
            cmd.run_next   = status.run_end;
         end
         S_OUT_READ: begin
            cmd.out_read = 1'b1;
         end
         S_OUT_SHOW: begin
            rsp_valid    = 1'b1;
            cmd.clear    = rsp_ready && status.out_last;
            cmd.out_next = rsp_ready && !status.out_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> design/ibs_datapath.sv
`timescale 1ns / 1ps

module ibs_datapath import ibs_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [DATA_W-1:0] req_value,
   output logic [DATA_W-1:0] rsp_sorted_value,
   output logic              rsp_final_res,
   output logic              rsp_overflow
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int WW = CW + 1;
   localparam int SW = CW + 2;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

   logic [DATA_W-1:0] mem0 [MAX_ITEMS];
   logic [DATA_W-1:0] mem1 [MAX_ITEMS];

   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [WW-1:0] width_ff, width_in;
   logic [CW-1:0] lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic          src_ff, src_in;
   logic [DATA_W-1:0] rd_i_ff, rd_j_ff;

   logic              room;
   logic              take_i;
   logic [SW-1:0]     mid_sum, hi_sum;
   logic [AW-1:0]     addr_a;
   logic              we0, we1;
   logic [AW-1:0]     waddr;
   logic [DATA_W-1:0] wdata;

   assign room    = count_ff < MAX_CNT;
   assign take_i  = (i_ff < mid_ff) &&
                    ((j_ff >= hi_ff) || ($signed(rd_i_ff) <= $signed(rd_j_ff)));
   assign mid_sum = SW'(lo_ff) + SW'(width_ff);
   assign hi_sum  = SW'(lo_ff) + SW'({width_ff, 1'b0});

   assign status.need_pass = SW'(width_ff) < SW'(count_ff);
   assign status.run_avail = lo_ff < count_ff;
   assign status.run_end   = (k_ff + 1'b1) == hi_ff;
   assign status.out_last  = (k_ff + 1'b1) == count_ff;

   assign rsp_sorted_value = rd_i_ff;
   assign rsp_final_res    = status.out_last;
   assign rsp_overflow     = dropped_ff;

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      width_in   = width_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      src_in     = src_ff;
      if (cmd.store) begin
         if (room) count_in = count_ff + 1'b1;
         else dropped_in = 1'b1;
      end
      if (cmd.pass_init) begin
         width_in = WW'(1);
         lo_in    = '0;
         src_in   = 1'b0;
      end
      if (cmd.pass_next) begin
         width_in = {width_ff[WW-2:0], 1'b0};
         lo_in    = '0;
         src_in   = !src_ff;
      end
      if (cmd.run_init) begin
         mid_in = (mid_sum < SW'(count_ff)) ? mid_sum[CW-1:0] : count_ff;
         hi_in  = (hi_sum < SW'(count_ff)) ? hi_sum[CW-1:0] : count_ff;
         i_in   = lo_ff;
         j_in   = (mid_sum < SW'(count_ff)) ? mid_sum[CW-1:0] : count_ff;
         k_in   = lo_ff;
      end
      if (cmd.merge_step) begin
         k_in = k_ff + 1'b1;
         if (take_i) i_in = i_ff + 1'b1;
         else j_in = j_ff + 1'b1;
      end
      if (cmd.run_next) lo_in = hi_ff;
      if (cmd.out_init) k_in = '0;
      if (cmd.out_next) k_in = k_ff + 1'b1;
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      src_ff   <= src_in;
   end

   // bank 0 takes input items; merges write the bank opposite the source
   assign we0   = (cmd.store && room) || (cmd.merge_step && src_ff);
   assign we1   = cmd.merge_step && !src_ff;
   assign waddr = cmd.store ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign wdata = cmd.store ? req_value : (take_i ? rd_i_ff : rd_j_ff);
   assign addr_a = cmd.out_read ? k_ff[AW-1:0] : i_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (we0) mem0[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (we1) mem1[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_merge || cmd.out_read) begin
         rd_i_ff <= src_ff ? mem1[addr_a] : mem0[addr_a];
         rd_j_ff <= src_ff ? mem1[j_ff[AW-1:0]] : mem0[j_ff[AW-1:0]];
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("stored count above capacity");

   a_merge_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.merge_step |-> (k_ff < hi_ff) && ((i_ff < mid_ff) || (j_ff < hi_ff)))
      else $error("merge step outside its run");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0) && !dropped_ff)
      else $error("batch state not cleared");

   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.out_read |-> (k_ff < count_ff))
      else $error("output index past batch");
`endif

endmodule

>>> design/integer_block_sorter.sv
`timescale 1ns / 1ps

// Batch sorter for signed 32-bit values.
// req_ch carries value and last; items are taken while the block is idle.
// Items are stored until one with last set arrives (at most MAX_ITEMS are
// kept; further items are dropped and the batch is flagged as overflow).
// The stored batch is then merge sorted between two memory banks with one
// compare unit in ceil(log2 N) passes; each merge step reads a pair of
// items, then writes the smaller one, and each pass and each run adds
// control states. When no pass is needed (N = 1), the first result is
// valid after the pass-check and output-read states; otherwise it follows
// the sort. Results leave on rsp_ch in ascending signed order, each read
// from a bank before it is shown, with final_res on the last one and
// overflow on all of a flagged batch.
// No new item is accepted from the last item of a batch until its final
// result is taken. When the receiver stalls, the result on rsp_ch holds.
// Reset (synchronous) empties the batch and returns to idle; no memory
// clearing is needed.
module integer_block_sorter import ibs_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   ibs_req_if.sink   req_ch,
   ibs_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   ibs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ibs_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_ch.value),
      .rsp_sorted_value (rsp_ch.sorted_value),
      .rsp_final_res    (rsp_ch.final_res),
      .rsp_overflow     (rsp_ch.overflow)
   );

endmodule
